@@ sv/pba_pkg.sv @@
package pba_pkg;

  localparam int MAX_PAGES      = 65536;
  localparam int WORD_BITS      = 32;
  localparam int LOW_ZONE_WORDS = 8;
  localparam int NUM_WORDS      = MAX_PAGES / WORD_BITS;
  localparam int ADDR_W         = $clog2(NUM_WORDS);
  localparam int BIT_W          = $clog2(WORD_BITS);
  localparam int PAGE_W         = 16;
  localparam int CNT_W          = 17;
  localparam int KIND_W         = 3;
  localparam int STATUS_W       = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int LOW_END        = LOW_ZONE_WORDS * WORD_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_FLOOR  = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam word_t WORD_ONES = '1;
  localparam cnt_t  CNT_MAX   = CNT_W'(MAX_PAGES);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC_HIGH = 3'd0,
    KIND_ALLOC_LOW  = 3'd1,
    KIND_FREE       = 3'd2,
    KIND_RESERVE    = 3'd3,
    KIND_RELEASE    = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } cnt_dir_t;

  typedef struct packed {
    kind_t kind;
    page_t page;
    cnt_t  count;
    cnt_t  total;
    cnt_t  floor_page;
  } req_t;

  typedef struct packed {
    page_t    granted;
    status_t  status;
    cnt_dir_t dir;
    cnt_t     amount;
  } res_t;

  function automatic bit_idx_t lowest_set(input word_t v);
    bit_idx_t idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/page_bitmap_allocator.sv @@
// First-fit page frame allocator over a 2048 x 32-bit usage bitmap held in
// one single-port-write RAM. After reset an initialization pass over all 2048
// words marks every page used; in_stall stays high until it ends. Each
// transaction then walks the bitmap one word per cycle with read-modify-write:
// an allocate scans up to 7 words in the low zone or up to total_pages/32 - 8
// in the high zone, a checked free reads one word, and a range reserve or
// release visits each 32-bit word the range covers. Out-of-range frees,
// empty ranges, unknown kinds and high-zone allocates with total_pages at or
// below 256 skip the walk and go straight to the result.
// One transaction is in flight at a time; a finished result waits in the
// output register while the next transaction is taken.
module page_bitmap_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pba_pkg::KIND_W-1:0]     in_kind,
  input  logic [pba_pkg::PAGE_W-1:0]     in_page,
  input  logic [pba_pkg::CNT_W-1:0]      in_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pba_pkg::PAGE_W-1:0]     out_granted_page,
  output logic [pba_pkg::STATUS_W-1:0]   out_status,
  output logic [pba_pkg::CNT_W-1:0]      out_pages_used,
  input  logic                           cfg_wr_en,
  input  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pba_pkg::CNT_W-1:0]      cfg_wdata
);

  pba_pkg::cnt_t    total_r;
  pba_pkg::cnt_t    floor_r;
  pba_pkg::cnt_t    cnt_r, cnt_nxt;
  logic             out_valid_r;
  pba_pkg::page_t   granted_r;
  pba_pkg::status_t status_r;

  pba_pkg::req_t    req;
  pba_pkg::res_t    res;
  logic             seq_ready;
  logic             res_valid;
  logic             load;
  logic             start;
  logic [pba_pkg::CNT_W:0] sum;

  assign req = '{kind: pba_pkg::kind_t'(in_kind), page: in_page, count: in_count,
                 total: total_r, floor_page: floor_r};

  assign start    = in_valid && seq_ready;
  assign in_stall = !seq_ready;
  assign load     = res_valid && (!out_valid_r || !out_stall);

  pba_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_take  (load),
    .res       (res)
  );

  always_comb begin
    sum     = {1'b0, cnt_r} + {1'b0, res.amount};
    cnt_nxt = cnt_r;
    unique case (res.dir)
      pba_pkg::DIR_UP: begin
        cnt_nxt = (sum > {1'b0, pba_pkg::CNT_MAX}) ? pba_pkg::CNT_MAX
                                                   : sum[pba_pkg::CNT_W-1:0];
      end
      pba_pkg::DIR_DOWN: begin
        cnt_nxt = (cnt_r >= res.amount) ? (cnt_r - res.amount) : '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= pba_pkg::CNT_MAX;
      floor_r     <= pba_pkg::CNT_W'(512);
      cnt_r       <= pba_pkg::CNT_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_index == pba_pkg::CFG_TOTAL_PAGES)) begin
        total_r <= cfg_wdata;
      end
      if (cfg_wr_en && (cfg_index == pba_pkg::CFG_FREE_FLOOR)) begin
        floor_r <= cfg_wdata;
      end
      if (load) begin
        cnt_r       <= cnt_nxt;
        granted_r   <= res.granted;
        status_r    <= res.status;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_page = granted_r;
  assign out_status       = status_r;
  assign out_pages_used   = cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pba_pkg::CNT_MAX)
    else $error("used count above maximum");

  a_no_grant_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pba_pkg::ST_OK) |-> out_granted_page == '0)
    else $error("page granted with failing status");

  a_grant_outside_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    load && (res.dir == pba_pkg::DIR_UP) && (res.granted != '0)
      |-> res.granted >= pba_pkg::PAGE_W'(pba_pkg::WORD_BITS))
    else $error("granted page lies in the first bitmap word");

  a_up_no_decrease: assert property (@(posedge clk) disable iff (!rst_n)
    load && (res.dir == pba_pkg::DIR_UP) |=> cnt_r >= $past(cnt_r))
    else $error("used count fell on an increment");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_stall)
    else $error("new transaction taken while a result is pending");

endmodule

@@ sv/pba_ram.sv @@
module pba_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/pba_seq.sv @@
module pba_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  pba_pkg::req_t req,
  output logic          ready,
  output logic          res_valid,
  input  logic          res_take,
  output pba_pkg::res_t res
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  pba_pkg::kind_t       kind_r, kind_nxt;
  pba_pkg::addr_t       addr_r, addr_nxt;
  logic                 more_r, more_nxt;
  logic                 pend_r, pend_nxt;
  pba_pkg::addr_t       pend_addr_r, pend_addr_nxt;
  pba_pkg::addr_t       first_r, first_nxt;
  pba_pkg::addr_t       last_r, last_nxt;
  pba_pkg::bit_idx_t    lob_r, lob_nxt;
  pba_pkg::bit_idx_t    hib_r, hib_nxt;
  pba_pkg::res_t        res_r, res_nxt;

  logic                 wr_en;
  pba_pkg::addr_t       wr_addr;
  pba_pkg::word_t       wr_data;
  logic                 rd_en;
  pba_pkg::word_t       rd_data;

  pba_pkg::cnt_t        hi_lim;
  pba_pkg::cnt_t        hi_m1;
  pba_pkg::cnt_t        room;
  pba_pkg::cnt_t        run_len;
  pba_pkg::cnt_t        end_m1;
  pba_pkg::word_t       lo_mask;
  pba_pkg::word_t       hi_mask;
  pba_pkg::word_t       mask;
  pba_pkg::word_t       free_bits;
  pba_pkg::bit_idx_t    idx;
  logic                 finish;

  pba_ram #(
    .DEPTH (pba_pkg::NUM_WORDS),
    .WIDTH (pba_pkg::WORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign ready     = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    hi_lim  = (req.total > pba_pkg::CNT_MAX) ? pba_pkg::CNT_MAX : req.total;
    hi_m1   = hi_lim - pba_pkg::CNT_W'(1);
    room    = pba_pkg::CNT_MAX - {1'b0, req.page};
    run_len = (req.count < room) ? req.count : room;
    end_m1  = {1'b0, req.page} + run_len - pba_pkg::CNT_W'(1);

    lo_mask   = pba_pkg::WORD_ONES << lob_r;
    hi_mask   = pba_pkg::WORD_ONES >> (pba_pkg::BIT_W'(pba_pkg::WORD_BITS - 1) - hib_r);
    mask      = ((pend_addr_r == first_r) ? lo_mask : pba_pkg::WORD_ONES) &
                ((pend_addr_r == last_r)  ? hi_mask : pba_pkg::WORD_ONES);
    free_bits = ~rd_data & mask;
    idx       = pba_pkg::lowest_set(free_bits);
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    more_nxt      = more_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    lob_nxt       = lob_r;
    hib_nxt       = hib_r;
    res_nxt       = res_r;
    wr_en         = 1'b0;
    wr_addr       = pend_addr_r;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    finish        = 1'b0;

    unique case (state_r)
      S_INIT: begin
        wr_en    = 1'b1;
        wr_addr  = addr_r;
        wr_data  = pba_pkg::WORD_ONES;
        addr_nxt = addr_r + pba_pkg::ADDR_W'(1);
        if (addr_r == pba_pkg::ADDR_W'(pba_pkg::NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          kind_nxt  = req.kind;
          res_nxt   = '{granted: '0, status: pba_pkg::ST_OK,
                        dir: pba_pkg::DIR_NONE, amount: '0};
          more_nxt  = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_RUN;
          lob_nxt   = '0;
          hib_nxt   = pba_pkg::BIT_W'(pba_pkg::WORD_BITS - 1);
          unique case (req.kind)
            pba_pkg::KIND_ALLOC_LOW: begin
              first_nxt = pba_pkg::ADDR_W'(1);
              last_nxt  = pba_pkg::ADDR_W'(pba_pkg::LOW_ZONE_WORDS - 1);
            end
            pba_pkg::KIND_ALLOC_HIGH: begin
              first_nxt = pba_pkg::ADDR_W'(pba_pkg::LOW_ZONE_WORDS);
              last_nxt  = hi_m1[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
              hib_nxt   = hi_m1[pba_pkg::BIT_W-1:0];
              if (hi_lim <= pba_pkg::CNT_W'(pba_pkg::LOW_END)) begin
                res_nxt.status = pba_pkg::ST_NONE;
                state_nxt      = S_DONE;
              end
            end
            pba_pkg::KIND_FREE: begin
              first_nxt = req.page[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
              last_nxt  = req.page[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
              lob_nxt   = req.page[pba_pkg::BIT_W-1:0];
              hib_nxt   = req.page[pba_pkg::BIT_W-1:0];
              if (({1'b0, req.page} > req.total) ||
                  ({1'b0, req.page} < req.floor_page)) begin
                res_nxt.status = pba_pkg::ST_RANGE;
                state_nxt      = S_DONE;
              end
            end
            pba_pkg::KIND_RESERVE,
            pba_pkg::KIND_RELEASE: begin
              first_nxt      = req.page[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
              last_nxt       = end_m1[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
              lob_nxt        = req.page[pba_pkg::BIT_W-1:0];
              hib_nxt        = end_m1[pba_pkg::BIT_W-1:0];
              res_nxt.amount = run_len;
              res_nxt.dir    = (req.kind == pba_pkg::KIND_RESERVE) ?
                               pba_pkg::DIR_UP : pba_pkg::DIR_DOWN;
              if (run_len == '0) begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
          addr_nxt = first_nxt;
          if (state_nxt == S_DONE) begin
            more_nxt = 1'b0;
          end
        end
      end

      S_RUN: begin
        rd_en         = more_r;
        pend_nxt      = more_r;
        pend_addr_nxt = addr_r;
        if (more_r) begin
          addr_nxt = addr_r + pba_pkg::ADDR_W'(1);
          more_nxt = (addr_r != last_r);
        end
        if (pend_r) begin
          unique case (kind_r)
            pba_pkg::KIND_ALLOC_LOW,
            pba_pkg::KIND_ALLOC_HIGH: begin
              if (|free_bits) begin
                wr_en           = 1'b1;
                wr_data         = rd_data | (pba_pkg::word_t'(1) << idx);
                res_nxt.granted = {pend_addr_r, idx};
                res_nxt.dir     = pba_pkg::DIR_UP;
                res_nxt.amount  = pba_pkg::CNT_W'(1);
                finish          = 1'b1;
              end else if (pend_addr_r == last_r) begin
                res_nxt.status = pba_pkg::ST_NONE;
                finish         = 1'b1;
              end
            end
            pba_pkg::KIND_FREE: begin
              if (|(rd_data & mask)) begin
                wr_en          = 1'b1;
                wr_data        = rd_data & ~mask;
                res_nxt.dir    = pba_pkg::DIR_DOWN;
                res_nxt.amount = pba_pkg::CNT_W'(1);
              end else begin
                res_nxt.status = pba_pkg::ST_DOUBLE;
              end
              finish = 1'b1;
            end
            pba_pkg::KIND_RESERVE: begin
              wr_en   = 1'b1;
              wr_data = rd_data | mask;
              finish  = (pend_addr_r == last_r);
            end
            pba_pkg::KIND_RELEASE: begin
              wr_en   = 1'b1;
              wr_data = rd_data & ~mask;
              finish  = (pend_addr_r == last_r);
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
        if (finish) begin
          state_nxt = S_DONE;
          more_nxt  = 1'b0;
          pend_nxt  = 1'b0;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      addr_r  <= '0;
      more_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      more_r      <= more_nxt;
      pend_r      <= pend_nxt;
      kind_r      <= kind_nxt;
      pend_addr_r <= pend_addr_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      lob_r       <= lob_nxt;
      hib_r       <= hib_nxt;
      res_r       <= res_nxt;
    end
  end

endmodule

@@ dv/page_alloc_sb_pkg.sv @@
package page_alloc_sb_pkg;
  import pba_pkg::*;

  typedef struct packed {
    page_t   granted;
    status_t status;
    cnt_t    used;
  } outcome_t;

  class page_alloc_scoreboard;
    bit [WORD_BITS-1:0] usage_map [NUM_WORDS];
    int unsigned        used_pages;
    int unsigned        total_pages;
    int unsigned        floor_page;
    outcome_t           pending_outcomes[$];
    page_t              granted_pages[$];
    int unsigned        mismatches;

    function new();
      foreach (usage_map[w]) begin
        usage_map[w] = '1;
      end
      used_pages  = MAX_PAGES;
      total_pages = MAX_PAGES;
      floor_page  = 512;
      mismatches  = 0;
    endfunction

    function void set_regs(int unsigned total, int unsigned floor_p);
      total_pages = total;
      floor_page  = floor_p;
    endfunction

    function bit page_used(int unsigned p);
      return usage_map[p / WORD_BITS][p % WORD_BITS];
    endfunction

    function void mark(int unsigned p, bit v);
      usage_map[p / WORD_BITS][p % WORD_BITS] = v;
    endfunction

    function void add_used();
      if (used_pages < MAX_PAGES) begin
        used_pages++;
      end
    endfunction

    function void drop_used();
      if (used_pages != 0) begin
        used_pages--;
      end
    endfunction

    // lowest free page in [lo, hi), skipping full words
    function bit find_free(int unsigned lo, int unsigned hi, output int unsigned found);
      int unsigned p;
      if (hi > MAX_PAGES) begin
        hi = MAX_PAGES;
      end
      p = lo;
      while (p < hi) begin
        if (p % WORD_BITS == 0 && usage_map[p / WORD_BITS] == '1) begin
          p += WORD_BITS;
        end else if (!page_used(p)) begin
          found = p;
          return 1'b1;
        end else begin
          p++;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, page_t page, cnt_t count);
      outcome_t    res;
      int unsigned found;
      bit          ok;
      res.granted = '0;
      res.status  = ST_OK;
      case (kind)
        KIND_ALLOC_HIGH, KIND_ALLOC_LOW: begin
          if (kind == KIND_ALLOC_LOW) begin
            ok = find_free(WORD_BITS, LOW_END, found);
          end else begin
            ok = find_free(LOW_END, total_pages, found);
          end
          if (ok) begin
            mark(found, 1'b1);
            add_used();
            res.granted = page_t'(found);
            granted_pages.push_back(res.granted);
          end else begin
            res.status = ST_NONE;
          end
        end
        KIND_FREE: begin
          if (page > total_pages || page < floor_page) begin
            res.status = ST_RANGE;
          end else if (!page_used(page)) begin
            res.status = ST_DOUBLE;
          end else begin
            mark(page, 1'b0);
            drop_used();
          end
        end
        KIND_RESERVE, KIND_RELEASE: begin
          for (int i = 0; i < count && page + i < MAX_PAGES; i++) begin
            mark(page + i, kind == KIND_RESERVE);
            if (kind == KIND_RESERVE) begin
              add_used();
            end else begin
              drop_used();
            end
          end
        end
        default: begin
        end
      endcase
      res.used = cnt_t'(used_pages);
      pending_outcomes.push_back(res);
    endfunction

    function void check_result(page_t granted, logic [STATUS_W-1:0] status, cnt_t used);
      outcome_t exp;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: granted_page %0d status %0d", granted,
               status);
        mismatches++;
        return;
      end
      exp = pending_outcomes.pop_front();
      if (granted !== exp.granted) begin
        $error("granted_page: expected %0d, got %0d", exp.granted, granted);
        mismatches++;
      end
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatches++;
      end
      if (used !== exp.used) begin
        $error("pages_used: expected %0d, got %0d", exp.used, used);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ dv/tb_top.sv @@
module tb_top;
  import pba_pkg::*;
  import page_alloc_sb_pkg::*;

  localparam int IDLE_PCT    = 16;
  localparam int HOLD_CYCLES = 500;
  localparam int QUIET_LIMIT = 40000;
  localparam logic [KIND_W-1:0] KIND_TOP = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind = '0;
  page_t                in_page = '0;
  cnt_t                 in_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  page_t                out_granted_page;
  logic [STATUS_W-1:0]  out_status;
  cnt_t                 out_pages_used;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  cnt_t                 cfg_wdata = '0;

  page_alloc_scoreboard scb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  page_bitmap_allocator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_page          (in_page),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_page (out_granted_page),
    .out_status       (out_status),
    .out_pages_used   (out_pages_used),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic send(input logic [KIND_W-1:0] kind, input page_t page, input cnt_t count);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_page  <= page;
    in_count <= count;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    scb.note_request(kind, page, count);
  endtask

  task automatic program_regs(input int unsigned total, input int unsigned floor_p);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TOTAL_PAGES;
    cfg_wdata <= cnt_t'(total);
    @(posedge clk);
    cfg_index <= CFG_FREE_FLOOR;
    cfg_wdata <= cnt_t'(floor_p);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scb.set_regs(total, floor_p);
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (scb.pending_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic random_burst(input int n, input int calm_items, input int hold_at);
    logic [KIND_W-1:0] kind;
    page_t             page;
    cnt_t              count;
    int                r;
    int                idx;
    int unsigned       top;
    for (int k = 0; k < n; k++) begin
      calm = (k < calm_items);
      if (k == hold_at) begin
        hold_req = 1'b1;
      end
      top   = (scb.total_pages < MAX_PAGES) ? scb.total_pages : MAX_PAGES - 1;
      page  = page_t'($urandom_range(top));
      count = ($urandom_range(9) == 0) ? '0 : cnt_t'($urandom_range(64));
      r     = $urandom_range(99);
      if (r < 28) begin
        kind = KIND_ALLOC_HIGH;
      end else if (r < 42) begin
        kind = KIND_ALLOC_LOW;
      end else if (r < 66) begin
        kind = KIND_FREE;
        r = $urandom_range(99);
        if (r < 60 && scb.granted_pages.size() > 0) begin
          idx  = $urandom_range(scb.granted_pages.size() - 1);
          page = scb.granted_pages[idx];
          scb.granted_pages.delete(idx);
        end else if (r >= 85) begin
          page = page_t'($urandom());
        end
      end else if (r < 78) begin
        kind = KIND_RELEASE;
      end else if (r < 88) begin
        kind = KIND_RESERVE;
      end else if (r < 94) begin
        kind  = KIND_W'($urandom_range(KIND_TOP, KIND_RELEASE + 1));
        page  = page_t'($urandom());
        count = cnt_t'($urandom());
      end else if (r < 97) begin
        kind = KIND_RESERVE;
        page = page_t'($urandom());
      end else begin
        kind  = KIND_RELEASE;
        page  = page_t'($urandom());
        count = cnt_t'($urandom_range(MAX_PAGES));
      end
      send(kind, page, count);
    end
    calm = 1'b0;
  endtask

  // result side: random stall, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        scb.check_result(out_granted_page, out_status, out_pages_used);
      end
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    program_regs(MAX_PAGES, 512);

    // everything used after reset
    send(KIND_ALLOC_HIGH, '0, '0);
    send(KIND_ALLOC_LOW, '0, '0);
    for (int k = KIND_RELEASE + 1; k <= KIND_TOP; k++) begin
      send(k[KIND_W-1:0], '1, '1);
    end
    send(KIND_FREE, 16'd511, '0);
    send(KIND_FREE, 16'd512, '0);
    send(KIND_FREE, 16'd512, '0);
    send(KIND_FREE, '1, '0);
    send(KIND_RESERVE, '1, 17'd2);
    send(KIND_RESERVE, 16'd100, '0);
    send(KIND_RELEASE, 16'd100, '0);
    send(KIND_RELEASE, '0, cnt_t'(MAX_PAGES));
    send(KIND_RELEASE, 16'd40, 17'd3);
    send(KIND_ALLOC_LOW, '0, '0);
    send(KIND_ALLOC_HIGH, '0, '0);
    send(KIND_FREE, page_t'(LOW_END), '0);
    send(KIND_RESERVE, '0, cnt_t'(MAX_PAGES));
    send(KIND_RESERVE, 16'd10, 17'd5);
    send(KIND_RELEASE, '0, cnt_t'(MAX_PAGES - 1));
    settle();

    program_regs(1024, 256);
    send(KIND_RESERVE, 16'd1024, 17'd2);
    send(KIND_FREE, 16'd1024, '0);
    send(KIND_FREE, 16'd1025, '0);
    send(KIND_RESERVE, page_t'(LOW_END), cnt_t'(1024 - LOW_END));
    send(KIND_ALLOC_HIGH, '0, '0);
    send(KIND_RELEASE, page_t'(LOW_END), cnt_t'(1024 - LOW_END));
    random_burst(200, 0, 60);
    settle();

    program_regs(LOW_END, 0);
    random_burst(200, 120, -1);
    settle();

    program_regs($urandom_range(8192, 300), MAX_PAGES);
    random_burst(160, 0, -1);
    settle();

    program_regs(MAX_PAGES, WORD_BITS);
    random_burst(240, 0, -1);
    settle();

    repeat (40) @(posedge clk);
    if (scb.mismatches == 0 && scb.pending_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
